FILE: sv/owrf_pkg.sv
// Shared types and constants for the overwriting ring FIFO with match count.
package owrf_pkg;

    // Built sizes of the buffer.
    localparam int DEPTH_DEF     = 16;
    localparam int ELEM_BITS_DEF = 32;

    // Fixed widths of the request and response fields.
    localparam int DATA_W    = 32;
    localparam int CNT_OUT_W = 5;
    localparam int CAP_W     = 5;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK     = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic [DATA_W-1:0] MASK_RESET = 32'hFFFF_FFFF;

    // Operation codes carried by a request.
    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_COUNT = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // Controller states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_POP  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_LAST = 4'b1000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // a request is taken this cycle
        logic scan_rd;     // issue the next read of a count scan
        logic pop_done;    // pop read data is ready, load the response
        logic count_done;  // last compare of a scan, load the response
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;       // no stored elements
        logic scan_last;   // the read issued now is the last one of the scan
    } t_dp_stat;

endpackage

FILE: sv/owrf_in_if.sv
// Request channel of the ring FIFO: valid, ready and the request fields.
interface owrf_in_if;
    import owrf_pkg::*;

    logic              valid;
    logic              ready;
    t_action           action;
    logic [DATA_W-1:0] data_in;

    modport source (output valid, action, data_in, input ready);
    modport sink   (input valid, action, data_in, output ready);
endinterface

FILE: sv/owrf_out_if.sv
// Response channel of the ring FIFO: valid, ready and the response fields.
interface owrf_out_if;
    import owrf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DATA_W-1:0]    data_out;
    logic                 data_out_valid;
    logic [CNT_OUT_W-1:0] match_count;
    logic [CNT_OUT_W-1:0] fill_level;
    logic                 overwrote;

    modport source (output valid, data_out, data_out_valid, match_count, fill_level,
                    overwrote, input ready);
    modport sink   (input valid, data_out, data_out_valid, match_count, fill_level,
                    overwrote, output ready);
endinterface

FILE: sv/overwriting_ring_fifo_with_match_count_unit.sv
// Top level of the overwriting ring FIFO with masked match count.
//
// Requests arrive on i_req (valid/ready) with an action and a data word; each request
// yields exactly one response on o_rsp (valid/ready). Push appends the word and, when
// the buffer holds its configured capacity, drops the oldest entries and flags it.
// Pop returns the oldest entry with a valid flag. Count returns how many stored
// entries equal the word on the bits set in the compare mask.
// Push, no-op and operations on an empty buffer respond in the cycle after the request.
// Pop waits in ST_POP for the registered storage read. Count walks the stored entries
// through the single read port, one per cycle, in ST_SCAN and responds from ST_LAST.
// One request is in flight at a time; a new one is taken in the cycle its predecessor's
// response is taken, or in any later cycle once the response register is empty.
// When the receiver stalls, the response register holds and no new request is taken.
// Reset empties the buffer and sets capacity to 16 and the compare mask to all ones;
// storage contents are not cleared. Configuration writes go through i_cfg_we,
// i_cfg_index (0 capacity, 1 compare mask) and i_cfg_data; the user must make them
// only while the block is idle, as the block itself does not enforce it.
module overwriting_ring_fifo_with_match_count_unit #(
    parameter int DEPTH     = owrf_pkg::DEPTH_DEF,
    parameter int ELEM_BITS = owrf_pkg::ELEM_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    owrf_in_if.sink                        i_req,
    owrf_out_if.source                     o_rsp,
    input  logic                           i_cfg_we,
    input  logic [owrf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [owrf_pkg::DATA_W-1:0]    i_cfg_data
);
    import owrf_pkg::*;

    t_ctrl_cmd            cmd;
    t_dp_stat             stat;
    logic                 in_ready;
    logic                 out_valid;
    logic [DATA_W-1:0]    data_out;
    logic                 data_out_valid;
    logic [CNT_OUT_W-1:0] match_count;
    logic [CNT_OUT_W-1:0] fill_level;
    logic                 overwrote;

    // Sequencing and handshake.
    owrf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_action    (i_req.action),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    // Storage and arithmetic.
    owrf_dp #(
        .DEPTH     (DEPTH),
        .ELEM_BITS (ELEM_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_action         (i_req.action),
        .i_data_in        (i_req.data_in),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_stat           (stat),
        .o_data_out       (data_out),
        .o_data_out_valid (data_out_valid),
        .o_match_count    (match_count),
        .o_fill_level     (fill_level),
        .o_overwrote      (overwrote)
    );

    // Channel wiring.
    assign i_req.ready          = in_ready;
    assign o_rsp.valid          = out_valid;
    assign o_rsp.data_out       = data_out;
    assign o_rsp.data_out_valid = data_out_valid;
    assign o_rsp.match_count    = match_count;
    assign o_rsp.fill_level     = fill_level;
    assign o_rsp.overwrote      = overwrote;
endmodule

FILE: sv/owrf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module owrf_ram #(
    parameter int WIDTH = owrf_pkg::ELEM_BITS_DEF,
    parameter int DEPTH = owrf_pkg::DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/owrf_ctrl.sv
// Controller of the ring FIFO: request handshake, operation sequencing, response valid.
module owrf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  owrf_pkg::t_action   i_action,
    input  logic                i_out_ready,
    input  owrf_pkg::t_dp_stat  i_stat,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output owrf_pkg::t_ctrl_cmd o_cmd
);
    import owrf_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   load_now;

    // A request is taken only when idle and the response register is free or draining.
    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    assign o_cmd.accept     = accept;
    assign o_cmd.scan_rd    = (r_state == ST_SCAN);
    assign o_cmd.pop_done   = (r_state == ST_POP);
    assign o_cmd.count_done = (r_state == ST_LAST);

    // Next state and the cycle in which a response is complete.
    always_comb begin
        n_state  = r_state;
        load_now = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_action)
                        ACT_POP: begin
                            if (i_stat.empty) begin
                                load_now = 1'b1;
                            end else begin
                                n_state = ST_POP;
                            end
                        end
                        ACT_COUNT: begin
                            if (i_stat.empty) begin
                                load_now = 1'b1;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                            load_now = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP: begin
                load_now = 1'b1;
                n_state  = ST_IDLE;
            end
            ST_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                load_now = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Response valid holds until the receiver takes it.
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (load_now) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

FILE: sv/owrf_dp.sv
// Datapath of the ring FIFO: pointers, fill count, configuration, storage and match counter.
module owrf_dp #(
    parameter int DEPTH     = owrf_pkg::DEPTH_DEF,
    parameter int ELEM_BITS = owrf_pkg::ELEM_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  owrf_pkg::t_ctrl_cmd               i_cmd,
    input  owrf_pkg::t_action                 i_action,
    input  logic [owrf_pkg::DATA_W-1:0]       i_data_in,
    input  logic                              i_cfg_we,
    input  logic [owrf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [owrf_pkg::DATA_W-1:0]       i_cfg_data,
    output owrf_pkg::t_dp_stat                o_stat,
    output logic [owrf_pkg::DATA_W-1:0]       o_data_out,
    output logic                              o_data_out_valid,
    output logic [owrf_pkg::CNT_OUT_W-1:0]    o_match_count,
    output logic [owrf_pkg::CNT_OUT_W-1:0]    o_fill_level,
    output logic                              o_overwrote
);
    import owrf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    // Ring state and configuration.
    logic [AW-1:0]        r_head;
    logic [CW-1:0]        r_fill;
    logic [CAP_W-1:0]     r_cap;
    logic [DATA_W-1:0]    r_mask;

    // Scan state.
    logic [AW-1:0]        r_rd_ptr;
    logic [CW-1:0]        r_idx;
    logic [CW-1:0]        r_match;
    logic [ELEM_BITS-1:0] r_value;
    logic                 r_cmp_vld;

    // Response register.
    logic [DATA_W-1:0]    r_data_out;
    logic                 r_dvalid;
    logic [CNT_OUT_W-1:0] r_match_out;
    logic [CNT_OUT_W-1:0] r_fill_out;
    logic                 r_over;

    logic [CW-1:0]        eff_cap;
    logic                 full;
    logic [CW-1:0]        drop_cnt;
    logic [AW-1:0]        push_addr;
    logic [AW-1:0]        n_head;
    logic [CW-1:0]        n_fill;
    logic                 is_push;
    logic                 is_pop;
    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;
    logic [ELEM_BITS-1:0] ram_rdata;
    logic [ELEM_BITS-1:0] value_in;
    logic [ELEM_BITS-1:0] mask_e;
    logic                 hit;
    logic [CW-1:0]        match_total;

    // Sum of a pointer and an offset, brought back into the ring with one subtract.
    function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
        if (s >= SW'(DEPTH)) begin
            return AW'(s - SW'(DEPTH));
        end
        return AW'(s);
    endfunction

    // Capacity in use: zero acts as one, anything above the built depth as the depth.
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CW'(1);
        end else if (int'(r_cap) > DEPTH) begin
            eff_cap = CW'(DEPTH);
        end else begin
            eff_cap = CW'(r_cap);
        end
    end

    assign value_in  = ELEM_BITS'(i_data_in);
    assign mask_e    = ELEM_BITS'(r_mask);
    assign is_push   = i_cmd.accept && (i_action == ACT_PUSH);
    assign is_pop    = i_cmd.accept && (i_action == ACT_POP) && (r_fill != '0);
    assign full      = (r_fill >= eff_cap);
    assign drop_cnt  = r_fill - eff_cap + CW'(1);
    // The new element always lands just behind the newest stored one.
    assign push_addr = wrap(SW'(r_head) + SW'(r_fill));

    // Next head and fill count for push and pop.
    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        if (is_push) begin
            if (full) begin
                n_head = wrap(SW'(r_head) + SW'(drop_cnt));
                n_fill = eff_cap;
            end else begin
                n_fill = r_fill + CW'(1);
            end
        end else if (is_pop) begin
            n_head = wrap(SW'(r_head) + SW'(1));
            n_fill = r_fill - CW'(1);
        end
    end

    // Storage: pop reads at the head, a scan walks from the head one entry per cycle.
    assign ram_we    = is_push;
    assign ram_raddr = i_cmd.scan_rd ? r_rd_ptr : r_head;

    owrf_ram #(
        .WIDTH (ELEM_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (push_addr),
        .i_wdata (value_in),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Masked equality on the entry read in the previous cycle.
    assign hit         = (((ram_rdata ^ r_value) & mask_e) == '0);
    assign match_total = r_match + CW'(hit);

    assign o_stat.empty     = (r_fill == '0);
    assign o_stat.scan_last = (r_idx == (r_fill - CW'(1)));

    // Ring state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_fill    <= '0;
            r_cap     <= CAP_RESET;
            r_mask    <= MASK_RESET;
            r_cmp_vld <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_fill    <= n_fill;
            r_cmp_vld <= i_cmd.scan_rd;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CAPACITY: r_cap  <= CAP_W'(i_cfg_data);
                    CFG_MASK:     r_mask <= i_cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    // Scan pointer, index and running match count.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_ptr <= r_head;
            r_idx    <= '0;
            r_match  <= '0;
            r_value  <= value_in;
        end else if (i_cmd.scan_rd) begin
            r_rd_ptr <= wrap(SW'(r_rd_ptr) + SW'(1));
            r_idx    <= r_idx + CW'(1);
            if (r_cmp_vld) begin
                r_match <= match_total;
            end
        end
    end

    // Response register: immediate fields at the request, pop and count results later.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_data_out  <= '0;
            r_dvalid    <= 1'b0;
            r_match_out <= '0;
            r_fill_out  <= CNT_OUT_W'(n_fill);
            r_over      <= is_push && full;
        end else if (i_cmd.pop_done) begin
            r_data_out  <= DATA_W'(ram_rdata);
            r_dvalid    <= 1'b1;
        end else if (i_cmd.count_done) begin
            r_match_out <= CNT_OUT_W'(match_total);
        end
    end

    assign o_data_out       = r_data_out;
    assign o_data_out_valid = r_dvalid;
    assign o_match_count    = r_match_out;
    assign o_fill_level     = r_fill_out;
    assign o_overwrote      = r_over;
endmodule
